>>> rtl/core/polygon_point_inclusion_area_assert.svh
// Assertion macros for the polygon point inclusion block.
// Included by the top level; needs no package.
`ifndef POLYGON_POINT_INCLUSION_AREA_ASSERT_SVH
`define POLYGON_POINT_INCLUSION_AREA_ASSERT_SVH
`ifndef SYNTHESIS
`define PPIA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PPIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPIA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define PPIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/ppia_pkg.sv
// Shared types and constants for the polygon point inclusion block.
// Used by the controller, the datapath and the top level.
package ppia_pkg;

    localparam int COORD_W = 20;
    localparam int AREA_W = 43;
    localparam int PROD_W = 42;
    localparam int MIN_SIDES = 3;
    localparam logic [2:0] SIDE_COUNT_RESET = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_MUL_D,
        ST_MUL_A,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic wr_corner;
        logic start;
        logic rd_en;
        logic take_first;
        logic mul_d;
        logic mul_a;
        logic acc_area;
        logic eval_edge;
        logic advance;
        logic wrap;
        logic finish;
    } dp_cmd_t;

endpackage

>>> rtl/core/ppia_datapath.sv
// Datapath: corner store, shared multiplier pair, crossing and area logic.
// Depends on ppia_pkg; driven by ppia_ctrl through dp_cmd_t.
module ppia_datapath
    import ppia_pkg::*;
#(
    parameter int MAX_SIDES = 4
)
(
    input  logic                        clk,
    input  dp_cmd_t                     cmd,
    input  logic [$clog2(MAX_SIDES)-1:0] rd_addr,
    input  logic [1:0]                  vertex_slot,
    input  logic signed [COORD_W-1:0]   coord_x,
    input  logic signed [COORD_W-1:0]   coord_y,
    output logic                        inside_res,
    output logic                        on_boundary,
    output logic signed [AREA_W-1:0]    doubled_area
);

    localparam int AW = $clog2(MAX_SIDES);

    point_t corner_mem [MAX_SIDES];
    point_t rd_reg;
    point_t first_reg;
    point_t a_reg;
    point_t pt_reg;
    logic signed [PROD_W-1:0] prod_a_reg, prod_a_next;
    logic signed [PROD_W-1:0] prod_b_reg, prod_b_next;
    logic signed [AREA_W-1:0] area_reg;
    logic parity_reg;
    logic boundary_reg;
    logic inside_out_reg;
    logic boundary_out_reg;
    logic signed [AREA_W-1:0] area_out_reg;

    logic [AW-1:0] wr_addr;
    logic signed [COORD_W-1:0] ax, ay, bx, by, px, py;
    logic signed [COORD_W:0] op_a1, op_a2, op_b1, op_b2;
    logic signed [AREA_W-1:0] diff;
    logic straddle, upward, d_zero, cross_hit, box_hit;

    assign wr_addr = AW'(vertex_slot);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_corner && (32'(vertex_slot) < MAX_SIDES))
        begin
            corner_mem[wr_addr] <= '{x: coord_x, y: coord_y};
        end
        if (cmd.rd_en)
        begin
            rd_reg <= corner_mem[rd_addr];
        end
    end

    assign ax = a_reg.x;
    assign ay = a_reg.y;
    assign bx = cmd.wrap ? first_reg.x : rd_reg.x;
    assign by = cmd.wrap ? first_reg.y : rd_reg.y;
    assign px = pt_reg.x;
    assign py = pt_reg.y;

    always_comb
    begin
        if (cmd.mul_a)
        begin
            op_a1 = {ax[COORD_W-1], ax};
            op_a2 = {by[COORD_W-1], by};
            op_b1 = {ay[COORD_W-1], ay};
            op_b2 = {bx[COORD_W-1], bx};
        end
        else
        begin
            op_a1 = {py[COORD_W-1], py} - {ay[COORD_W-1], ay};
            op_a2 = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
            op_b1 = {px[COORD_W-1], px} - {ax[COORD_W-1], ax};
            op_b2 = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
        end
        prod_a_next = op_a1 * op_a2;
        prod_b_next = op_b1 * op_b2;
    end

    assign diff = {prod_a_reg[PROD_W-1], prod_a_reg} - {prod_b_reg[PROD_W-1], prod_b_reg};

    // The point is compared with each coordinate span of the edge.
    always_comb
    begin
        straddle = (ay >= py) != (by >= py);
        upward = by >= ay;
        d_zero = diff == '0;
        cross_hit = straddle && (upward ? !diff[AREA_W-1] : (d_zero || diff[AREA_W-1]));
        box_hit = (px >= ax || px >= bx) && (px <= ax || px <= bx)
            && (py >= ay || py >= by) && (py <= ay || py <= by);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pt_reg <= '{x: coord_x, y: coord_y};
        end
        if (cmd.take_first)
        begin
            first_reg <= rd_reg;
            a_reg <= rd_reg;
            area_reg <= '0;
            parity_reg <= 1'b0;
            boundary_reg <= 1'b0;
        end
        if (cmd.advance)
        begin
            a_reg <= rd_reg;
        end
        if (cmd.mul_d || cmd.mul_a)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (cmd.acc_area)
        begin
            area_reg <= area_reg + diff;
        end
        if (cmd.eval_edge)
        begin
            parity_reg <= parity_reg ^ cross_hit;
            boundary_reg <= boundary_reg | (d_zero && box_hit);
        end
        if (cmd.finish)
        begin
            area_out_reg <= area_reg + diff;
            inside_out_reg <= parity_reg | boundary_reg;
            boundary_out_reg <= boundary_reg;
        end
    end

    assign inside_res = inside_out_reg;
    assign on_boundary = boundary_out_reg;
    assign doubled_area = area_out_reg;

endmodule

>>> rtl/core/ppia_ctrl.sv
// Controller: sequences the edge walk and owns the handshake and side count.
// Depends on ppia_pkg; drives ppia_datapath through dp_cmd_t.
module ppia_ctrl
    import ppia_pkg::*;
#(
    parameter int MAX_SIDES = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    output logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_wr_data,
    output dp_cmd_t                      cmd,
    output logic [$clog2(MAX_SIDES)-1:0] rd_addr
);

    localparam int AW = $clog2(MAX_SIDES);
    localparam int CW = $clog2(MAX_SIDES + 2);

    ctl_state_t state_reg, state_next;
    logic [AW-1:0] edge_reg, edge_next;
    logic [2:0] side_count_reg;
    logic out_valid_reg, out_valid_next;

    logic [CW-1:0] sides;
    logic [CW-1:0] edge_ext;
    logic [CW-1:0] fetch_idx;
    logic last_edge;
    logic accept;
    logic out_free;

    always_comb
    begin
        priority if (side_count_reg < 3'(MIN_SIDES))
        begin
            sides = CW'(MIN_SIDES);
        end
        else if (32'(side_count_reg) > MAX_SIDES)
        begin
            sides = CW'(MAX_SIDES);
        end
        else
        begin
            sides = CW'(side_count_reg);
        end
    end

    assign edge_ext = CW'(edge_reg);
    assign fetch_idx = edge_ext + CW'(2);
    assign last_edge = (edge_ext + CW'(1)) == sides;
    assign accept = (state_reg == ST_IDLE) && in_valid;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_QUERY)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_MUL_A;
            ST_MUL_A:  state_next = last_edge ? ST_FINISH : ST_MUL_D;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        rd_addr = '0;
        edge_next = edge_reg;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.wr_corner = accept && command == CMD_LOAD;
                cmd.start = accept && command == CMD_QUERY;
                cmd.rd_en = accept && command == CMD_QUERY;
            end
            ST_FIRST:
            begin
                cmd.take_first = 1'b1;
                cmd.rd_en = 1'b1;
                rd_addr = AW'(1);
                edge_next = '0;
            end
            ST_MUL_D:
            begin
                cmd.mul_d = 1'b1;
                cmd.acc_area = edge_reg != '0;
                cmd.wrap = last_edge;
            end
            ST_MUL_A:
            begin
                cmd.mul_a = 1'b1;
                cmd.eval_edge = 1'b1;
                cmd.wrap = last_edge;
                if (!last_edge)
                begin
                    cmd.advance = 1'b1;
                    edge_next = edge_reg + AW'(1);
                    cmd.rd_en = fetch_idx < sides;
                    rd_addr = fetch_idx[AW-1:0];
                end
            end
            ST_FINISH:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid_next = cmd.finish || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            edge_reg <= '0;
            side_count_reg <= SIDE_COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg <= edge_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                side_count_reg <= cfg_wr_data;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/polygon_point_inclusion_area.sv
// Polygon point inclusion test with doubled shoelace area, top level.
// Depends on ppia_pkg, ppia_ctrl, ppia_datapath and the assertion header.
//
// The input channel carries load and query requests under in_valid and in_stall.
// A load request writes one corner into the store and never holds the input busy.
// A query request walks every edge of the polygon through one shared multiplier pair,
// in the states ST_FIRST, then ST_MUL_D and ST_MUL_A for each edge, then ST_FINISH,
// and holds the input busy from when it is taken until it returns to idle.
// The result appears in an output register under out_valid; while out_stall is
// high it holds, loads are still taken, and a new query runs up to its final
// cycle and waits there until the register is free.
// The side count register is written through cfg_wr_en and cfg_wr_data and resets to four;
// the user must write it only while the block is idle, as the block does not enforce it.
// Reset clears the controller and the output valid; corners are undefined until loaded.
`include "polygon_point_inclusion_area_assert.svh"

module polygon_point_inclusion_area
    import ppia_pkg::*;
#(
    parameter int MAX_SIDES = 4
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic [1:0]                vertex_slot,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      inside_res,
    output logic                      on_boundary,
    output logic signed [AREA_W-1:0]  doubled_area,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_wr_data
);

    dp_cmd_t cmd;
    logic [$clog2(MAX_SIDES)-1:0] rd_addr;

    ppia_ctrl #(
        .MAX_SIDES (MAX_SIDES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    ppia_datapath #(
        .MAX_SIDES (MAX_SIDES)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .vertex_slot  (vertex_slot),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .inside_res   (inside_res),
        .on_boundary  (on_boundary),
        .doubled_area (doubled_area)
    );

    `PPIA_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && !in_stall && command == CMD_QUERY, in_stall, "Query accepted but input not held busy")
    `PPIA_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid, "Finished query did not raise out_valid")
    `PPIA_ASSERT_ALWAYS(a_one_phase, clk, rst_n, $onehot0({cmd.take_first, cmd.mul_d, cmd.mul_a, cmd.finish}), "More than one datapath phase active")

endmodule

>>> tb/polygon_point_inclusion_area_checker.sv
`timescale 1ns / 100ps
// Checker for the polygon point inclusion block: mirrors the corner store and the side
// count, predicts every query result and compares it field by field with the output.
// Depends on ppia_pkg for the coordinate and area widths.
module polygon_point_inclusion_area_checker
    import ppia_pkg::*;
#(
    parameter int MAX_SIDES = 4
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      command,
    input  logic [1:0]                vertex_slot,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      inside_res,
    input  logic                      on_boundary,
    input  logic signed [AREA_W-1:0]  doubled_area,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_wr_data,
    output int unsigned               error_count,
    output int unsigned               results_owed
);

    typedef struct packed {
        logic              in_poly;
        logic              boundary;
        logic [AREA_W-1:0] area;
    } inclusion_t;

    localparam int AW = $clog2(MAX_SIDES);

    logic signed [COORD_W-1:0] corner_x [MAX_SIDES];
    logic signed [COORD_W-1:0] corner_y [MAX_SIDES];
    logic [2:0]                side_setting = SIDE_COUNT_RESET;
    inclusion_t                pending_inclusions [$];
    inclusion_t                oldest;
    int unsigned               mismatch_tally = 0;

    task automatic report_mismatch(input string what, input logic [AREA_W-1:0] got,
                                   input logic [AREA_W-1:0] want);
        $display("%0t inclusion mismatch on %s: got %0h, wanted %0h", $time, what, got, want);
        mismatch_tally++;
    endtask

    function automatic inclusion_t crossing_inclusion(input logic signed [COORD_W-1:0] px,
                                                      input logic signed [COORD_W-1:0] py);
        int unsigned sides;
        int unsigned i;
        int unsigned nxt;
        int unsigned crossings;
        longint      lx, ly, x1, y1, x2, y2, cross_prod, area_sum;
        logic        touches;
        inclusion_t  res;
        sides = 32'(side_setting);
        if (sides < MIN_SIDES)
            sides = MIN_SIDES;
        if (sides > MAX_SIDES)
            sides = MAX_SIDES;
        lx = longint'(px);
        ly = longint'(py);
        crossings = 0;
        touches = 1'b0;
        area_sum = 0;
        for (i = 0; i < sides; i++)
        begin
            nxt = (i + 1 == sides) ? 0 : i + 1;
            x1 = longint'(corner_x[AW'(i)]);
            y1 = longint'(corner_y[AW'(i)]);
            x2 = longint'(corner_x[AW'(nxt)]);
            y2 = longint'(corner_y[AW'(nxt)]);
            cross_prod = (ly - y1) * (x2 - x1) - (lx - x1) * (y2 - y1);
            area_sum += x1 * y2 - y1 * x2;
            if ((y1 >= ly) != (y2 >= ly))
            begin
                if (y2 >= y1)
                    crossings += (cross_prod >= 0) ? 1 : 0;
                else
                    crossings += (cross_prod <= 0) ? 1 : 0;
            end
            if (cross_prod == 0 && ((x1 <= lx && lx <= x2) || (x2 <= lx && lx <= x1))
                    && ((y1 <= ly && ly <= y2) || (y2 <= ly && ly <= y1)))
                touches = 1'b1;
        end
        res.boundary = touches;
        res.in_poly = touches | crossings[0];
        res.area = area_sum[AREA_W-1:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            side_setting = SIDE_COUNT_RESET;
            pending_inclusions.delete();
        end
        else
        begin
            if (cfg_wr_en)
                side_setting = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (pending_inclusions.size() == 0)
                    report_mismatch("result with no query pending", doubled_area, '0);
                else
                begin
                    oldest = pending_inclusions.pop_front();
                    if (inside_res !== oldest.in_poly)
                        report_mismatch("inside_res", inside_res, oldest.in_poly);
                    if (on_boundary !== oldest.boundary)
                        report_mismatch("on_boundary", on_boundary, oldest.boundary);
                    if (doubled_area !== oldest.area)
                        report_mismatch("doubled_area", doubled_area, oldest.area);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (command == CMD_QUERY)
                    pending_inclusions.push_back(crossing_inclusion(coord_x, coord_y));
                else if (vertex_slot < MAX_SIDES)
                begin
                    corner_x[AW'(vertex_slot)] = coord_x;
                    corner_y[AW'(vertex_slot)] = coord_y;
                end
            end
        end
        error_count <= mismatch_tally;
        results_owed <= pending_inclusions.size();
    end

endmodule

>>> tb/tb_polygon_point_inclusion_area.sv
`timescale 1ns / 100ps
// Testbench top for the polygon point inclusion block: issues load, query and side count
// requests under random idling and gives the verdict from the checker's failure count.
// Depends on ppia_pkg, polygon_point_inclusion_area and its checker module.
module tb_polygon_point_inclusion_area;
    import ppia_pkg::*;

    localparam int MAX_SIDES = 4;
    localparam int AW = $clog2(MAX_SIDES);
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 160;
    localparam int STALL_LIMIT = 3000;
    localparam int ROUND_ITEMS = 84;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      command = CMD_LOAD;
    logic [1:0]                vertex_slot = '0;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      inside_res;
    logic                      on_boundary;
    logic signed [AREA_W-1:0]  doubled_area;
    logic                      cfg_wr_en = 1'b0;
    logic [2:0]                cfg_wr_data = '0;

    int unsigned error_count;
    int unsigned results_owed;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_done = 0;
    int unsigned quiet_cycles = 0;
    int unsigned items_sent = 0;
    logic signed [COORD_W-1:0] loaded_x [MAX_SIDES];
    logic signed [COORD_W-1:0] loaded_y [MAX_SIDES];

    polygon_point_inclusion_area #(
        .MAX_SIDES(MAX_SIDES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .vertex_slot(vertex_slot),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .inside_res(inside_res),
        .on_boundary(on_boundary),
        .doubled_area(doubled_area),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    polygon_point_inclusion_area_checker #(
        .MAX_SIDES(MAX_SIDES)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .vertex_slot(vertex_slot),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .inside_res(inside_res),
        .on_boundary(on_boundary),
        .doubled_area(doubled_area),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .error_count(error_count),
        .results_owed(results_owed)
    );

    always #5 clk = ~clk;

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_done)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [COORD_W-1:0] pick_coord(input int unsigned reach);
        if (reach == 0)
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(2 * reach)) - int'(reach));
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_extreme();
        case ($urandom_range(2))
            0: return COORD_W'(COORD_MIN);
            1: return COORD_W'(COORD_MAX);
            default: return '0;
        endcase
    endfunction

    task automatic send_request(input logic cmd, input logic [1:0] slot,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        vertex_slot <= slot;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd == CMD_LOAD)
        begin
            loaded_x[slot] = x;
            loaded_y[slot] = y;
        end
        items_sent++;
    endtask

    task automatic load_corner(input logic [1:0] slot, input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        send_request(CMD_LOAD, slot, x, y);
    endtask

    task automatic query_point(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        send_request(CMD_QUERY, 2'($urandom), x, y);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    task automatic write_side_count(input logic [2:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_element();
        int unsigned reach;
        int unsigned slot;
        logic signed [COORD_W-1:0] ax, ay, bx, by;
        reach = ($urandom_range(7) == 0) ? 0 : (32'd1 << $urandom_range(18, 3));
        if ($urandom_range(2) == 0)
        begin
            ax = pick_coord(reach);
            ay = pick_coord(reach);
            bx = pick_coord(reach);
            by = pick_coord(reach);
            load_corner(2'd0, ax, ay);
            load_corner(2'd1, bx, ay);
            load_corner(2'd2, bx, by);
            load_corner(2'd3, ax, by);
        end
        else
        begin
            for (slot = 0; slot < MAX_SIDES; slot++)
                load_corner(2'(slot), pick_coord(reach), pick_coord(reach));
        end
    endtask

    task automatic query_near_element();
        int unsigned k;
        int unsigned nk;
        int unsigned t;
        longint x1, y1, x2, y2, lo_x, hi_x, lo_y, hi_y, qx, qy;
        k = $urandom_range(MAX_SIDES - 1);
        nk = (k + 1) % MAX_SIDES;
        x1 = longint'(loaded_x[AW'(k)]);
        y1 = longint'(loaded_y[AW'(k)]);
        x2 = longint'(loaded_x[AW'(nk)]);
        y2 = longint'(loaded_y[AW'(nk)]);
        lo_x = x1;
        hi_x = x1;
        lo_y = y1;
        hi_y = y1;
        for (t = 0; t < MAX_SIDES; t++)
        begin
            if (longint'(loaded_x[AW'(t)]) < lo_x) lo_x = longint'(loaded_x[AW'(t)]);
            if (longint'(loaded_x[AW'(t)]) > hi_x) hi_x = longint'(loaded_x[AW'(t)]);
            if (longint'(loaded_y[AW'(t)]) < lo_y) lo_y = longint'(loaded_y[AW'(t)]);
            if (longint'(loaded_y[AW'(t)]) > hi_y) hi_y = longint'(loaded_y[AW'(t)]);
        end
        case ($urandom_range(6))
            0:
            begin
                qx = x1;
                qy = y1;
            end
            1, 2:
            begin
                t = $urandom_range(8);
                qx = x1 + (x2 - x1) * longint'(t) / 8;
                qy = y1 + (y2 - y1) * longint'(t) / 8;
            end
            3:
            begin
                qx = lo_x + longint'($urandom_range(32'(hi_x - lo_x)));
                qy = lo_y + longint'($urandom_range(32'(hi_y - lo_y)));
            end
            4:
            begin
                qx = lo_x + longint'($urandom_range(32'(hi_x - lo_x)));
                qy = y1;
            end
            5:
            begin
                qx = longint'(pick_extreme());
                qy = longint'(pick_extreme());
            end
            default:
            begin
                qx = longint'(pick_coord(0));
                qy = longint'(pick_coord(0));
            end
        endcase
        query_point(qx[COORD_W-1:0], qy[COORD_W-1:0]);
    endtask

    initial
    begin : stimulus
        int unsigned mode_sel;
        int unsigned round;
        int unsigned round_start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        load_corner(2'd0, '0, '0);
        load_corner(2'd1, COORD_W'(1024), '0);
        load_corner(2'd2, COORD_W'(1024), COORD_W'(1024));
        load_corner(2'd3, '0, COORD_W'(1024));
        query_point(COORD_W'(512), COORD_W'(512));
        query_point(COORD_W'(2048), COORD_W'(512));
        query_point(COORD_W'(1024), COORD_W'(512));
        query_point('0, '0);
        query_point(COORD_W'(512), COORD_W'(1024));
        query_point(COORD_W'(512), '0);
        query_point(COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
        query_point(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
        load_corner(2'd0, COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
        load_corner(2'd1, COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
        load_corner(2'd2, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
        load_corner(2'd3, COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
        query_point('0, '0);
        query_point(COORD_W'(COORD_MAX), '0);
        query_point(COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
        write_side_count(3'd3);
        query_point('0, '0);
        query_point(COORD_W'(1000), COORD_W'(-1000));
        query_point(COORD_W'(-1000), COORD_W'(1000));
        write_side_count(3'd0);
        query_point(COORD_W'(-1000), COORD_W'(1000));
        write_side_count(3'd7);
        query_point(COORD_W'(-1000), COORD_W'(1000));

        for (mode_sel = 0; mode_sel < 3; mode_sel++)
        begin
            case (mode_sel)
                0:
                begin
                    sender_idle_pct = 23;
                    receiver_stall_pct <= 57;
                end
                1:
                begin
                    sender_idle_pct = 57;
                    receiver_stall_pct <= 23;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 0;
                end
            endcase
            for (round = 0; round < 4; round++)
            begin
                if (round == 0)
                    write_side_count((mode_sel == 0) ? 3'd7 : 3'd3);
                else
                    write_side_count(3'($urandom_range(7)));
                round_start = items_sent;
                if (mode_sel == 0 && round == 1)
                begin
                    holds_asked <= holds_asked + 1;
                    repeat (12) query_near_element();
                end
                while (items_sent - round_start < ROUND_ITEMS)
                begin
                    if ($urandom_range(9) == 0)
                        load_corner(2'($urandom), pick_coord(0), pick_coord(0));
                    else
                    begin
                        load_element();
                        repeat ($urandom_range(8, 3)) query_near_element();
                    end
                end
                if (round == 2)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ppia_pkg.sv
rtl/core/ppia_datapath.sv
rtl/core/ppia_ctrl.sv
rtl/core/polygon_point_inclusion_area.sv
tb/polygon_point_inclusion_area_checker.sv
tb/tb_polygon_point_inclusion_area.sv
